// ===== hw/rtl/cdq_pkg.sv =====
package cdq_pkg;

    localparam int DEPTH = 1024;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W = 11;
    localparam int OPC_W = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } op_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic             ok;
        logic             rd;
        logic             is_empty;
        logic             is_full;
        logic [CNT_W-1:0] fill_count;
    } step_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] value;
        logic                     is_empty;
        logic                     is_full;
        logic [CNT_W-1:0]         fill_count;
    } rsp_t;

endpackage

// ===== hw/rtl/cdq_req_if.sv =====
interface cdq_req_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink (input valid, input opcode, input push_value, output ready);
endinterface

// ===== hw/rtl/cdq_rsp_if.sv =====
interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] value;
    logic                     is_empty;
    logic                     is_full;
    logic [CNT_W-1:0]         fill_count;

    modport source (output valid, output ok, output value, output is_empty,
                    output is_full, output fill_count, input ready);
    modport sink (input valid, input ok, input value, input is_empty,
                  input is_full, input fill_count, output ready);
endinterface

// ===== hw/rtl/circular_deque_unit.sv =====
// Double-ended queue of signed 32-bit elements in a 1024-entry single-port memory.
// Each request item is one operation (push front or rear, pop front or rear, peek front
// or rear) and yields exactly one response item with ok, the element, and the empty flag,
// full flag and element count after the operation. The block takes one item per cycle
// while responses are taken; a result waits in the read stage for the synchronous memory
// read, then in the output register. Writing the capacity register empties the deque.
module circular_deque_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    cdq_req_if.sink                    req,
    cdq_rsp_if.source                  rsp,
    input  logic                       cfg_wr_en,
    input  logic [cdq_pkg::CNT_W-1:0]  cfg_wr_data
);
    import cdq_pkg::*;

    mem_req_t          mem_req;
    step_t             step;
    logic [DATA_W-1:0] rdata;
    logic              accept;
    logic              s1_adv;
    logic              out_adv;
    logic              s1_valid_reg;
    step_t             s1_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    cdq_ptr u_ptr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (req.opcode),
        .push_value  (req.push_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req),
        .step        (step)
    );

    cdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    assign out_adv   = !out_valid_reg || rsp.ready;
    assign s1_adv    = s1_valid_reg && out_adv;
    assign req.ready = !s1_valid_reg || out_adv;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= step;
        end
        if (s1_adv)
        begin
            out_reg.ok         <= s1_reg.ok;
            out_reg.value      <= s1_reg.rd ? rdata : '1;
            out_reg.is_empty   <= s1_reg.is_empty;
            out_reg.is_full    <= s1_reg.is_full;
            out_reg.fill_count <= s1_reg.fill_count;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_reg.ok;
    assign rsp.value      = out_reg.value;
    assign rsp.is_empty   = out_reg.is_empty;
    assign rsp.is_full    = out_reg.is_full;
    assign rsp.fill_count = out_reg.fill_count;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_adv |-> !req.ready)
        else $error("Request taken while the read stage is stalled.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step.fill_count <= CNT_W'(DEPTH))
        else $error("Element count exceeds the memory depth.");

    a_mem_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("Memory read and write requested together.");

    a_read_tracks_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mem_req.re |=> s1_valid_reg && s1_reg.ok && s1_reg.rd)
        else $error("Memory read issued for an item that reports no element.");
endmodule

// ===== hw/rtl/cdq_ram.sv =====
module cdq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/cdq_ptr.sv =====
module cdq_ptr (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [cdq_pkg::OPC_W-1:0]       opcode,
    input  logic [cdq_pkg::DATA_W-1:0]      push_value,
    input  logic                            cfg_wr_en,
    input  logic [cdq_pkg::CNT_W-1:0]       cfg_wr_data,
    output cdq_pkg::mem_req_t               mem_req,
    output cdq_pkg::step_t                  step
);
    import cdq_pkg::*;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  eff_cap;
    logic              has_elem;
    logic              full;
    logic [ADDR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [CNT_W-1:0]  head_plus, tail_plus, cap_minus;

    always_comb
    begin
        eff_cap   = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
        has_elem  = (count_reg != '0);
        full      = (count_reg >= eff_cap);
        cap_minus = eff_cap - CNT_W'(1);
        head_plus = CNT_W'(head_reg) + CNT_W'(1);
        tail_plus = CNT_W'(tail_reg) + CNT_W'(1);
        head_inc  = (head_plus >= eff_cap) ? '0 : head_plus[ADDR_W-1:0];
        tail_inc  = (tail_plus >= eff_cap) ? '0 : tail_plus[ADDR_W-1:0];
        head_dec  = (head_reg == '0) ? cap_minus[ADDR_W-1:0] : head_reg - ADDR_W'(1);
        tail_dec  = (tail_reg == '0) ? cap_minus[ADDR_W-1:0] : tail_reg - ADDR_W'(1);
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = head_reg;
        mem_req.wdata = push_value;
        step.ok       = 1'b0;
        step.rd       = 1'b0;
        unique case (opcode)
            OP_PUSH_FRONT:
            begin
                if (!full)
                begin
                    head_next    = head_dec;
                    count_next   = count_reg + CNT_W'(1);
                    mem_req.we   = accept;
                    mem_req.addr = head_dec;
                    step.ok      = 1'b1;
                end
            end
            OP_PUSH_REAR:
            begin
                if (!full)
                begin
                    tail_next    = tail_inc;
                    count_next   = count_reg + CNT_W'(1);
                    mem_req.we   = accept;
                    mem_req.addr = tail_reg;
                    step.ok      = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (has_elem)
                begin
                    head_next    = head_inc;
                    count_next   = count_reg - CNT_W'(1);
                    mem_req.re   = accept;
                    mem_req.addr = head_reg;
                    step.ok      = 1'b1;
                    step.rd      = 1'b1;
                end
            end
            OP_POP_REAR:
            begin
                if (has_elem)
                begin
                    tail_next    = tail_dec;
                    count_next   = count_reg - CNT_W'(1);
                    mem_req.re   = accept;
                    mem_req.addr = tail_dec;
                    step.ok      = 1'b1;
                    step.rd      = 1'b1;
                end
            end
            OP_PEEK_FRONT:
            begin
                if (has_elem)
                begin
                    mem_req.re   = accept;
                    mem_req.addr = head_reg;
                    step.ok      = 1'b1;
                    step.rd      = 1'b1;
                end
            end
            OP_PEEK_REAR:
            begin
                if (has_elem)
                begin
                    mem_req.re   = accept;
                    mem_req.addr = tail_dec;
                    step.ok      = 1'b1;
                    step.rd      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        step.is_empty   = (count_next == '0);
        step.is_full    = (count_next >= eff_cap);
        step.fill_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= cfg_wr_data;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end
endmodule

// ===== tb/sv/circular_deque_unit_tb.sv =====
module circular_deque_unit_tb;
    import cdq_pkg::*;

    localparam logic [OPC_W-1:0] OP_NOP_LOW  = 3'd6;
    localparam logic [OPC_W-1:0] OP_NOP_HIGH = 3'd7;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        logic [OPC_W-1:0]         code;
        logic signed [DATA_W-1:0] arg;
    } deque_op_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    cdq_req_if req_ch ();
    cdq_rsp_if rsp_ch ();

    circular_deque_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    logic [DATA_W-1:0] slot_mem [DEPTH];
    int front_pos;
    int back_pos;
    int held;
    int cap_limit;

    deque_op_t pending_ops [$];
    rsp_t      want_rsp [$];

    op_t push_ops [2] = '{OP_PUSH_FRONT, OP_PUSH_REAR};
    op_t read_ops [4] = '{OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR};

    int errors = 0;
    int n_ops = 0;
    int n_refused = 0;
    int n_empty_reads = 0;
    int n_full_seen = 0;
    int n_caps = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_ticket = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet = 0;

    always #4 clk = ~clk;

    function automatic int step_back(int pos);
        return (pos == 0) ? cap_limit - 1 : pos - 1;
    endfunction

    function automatic int step_fwd(int pos);
        return (pos + 1 >= cap_limit) ? 0 : pos + 1;
    endfunction

    function automatic rsp_t deque_step(logic [OPC_W-1:0] code, logic [DATA_W-1:0] arg);
        rsp_t r;
        logic has;
        logic full;
        has = (held != 0);
        full = (held >= cap_limit);
        r.ok = 1'b0;
        r.value = '1;
        case (code)
            OP_PUSH_FRONT:
                if (!full)
                begin
                    front_pos = step_back(front_pos);
                    slot_mem[front_pos] = arg;
                    held++;
                    r.ok = 1'b1;
                end
            OP_PUSH_REAR:
                if (!full)
                begin
                    slot_mem[back_pos] = arg;
                    back_pos = step_fwd(back_pos);
                    held++;
                    r.ok = 1'b1;
                end
            OP_POP_FRONT:
                if (has)
                begin
                    r.value = slot_mem[front_pos];
                    front_pos = step_fwd(front_pos);
                    held--;
                    r.ok = 1'b1;
                end
            OP_POP_REAR:
                if (has)
                begin
                    back_pos = step_back(back_pos);
                    r.value = slot_mem[back_pos];
                    held--;
                    r.ok = 1'b1;
                end
            OP_PEEK_FRONT:
                if (has)
                begin
                    r.value = slot_mem[front_pos];
                    r.ok = 1'b1;
                end
            OP_PEEK_REAR:
                if (has)
                begin
                    r.value = slot_mem[step_back(back_pos)];
                    r.ok = 1'b1;
                end
            default: ;
        endcase
        r.is_empty = (held == 0);
        r.is_full = (held >= cap_limit);
        r.fill_count = CNT_W'(held);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [OPC_W-1:0] code, logic [DATA_W-1:0] arg);
        pending_ops.push_back('{code, arg});
    endtask

    task automatic queue_random(int n, int push_pct);
        deque_op_t item;
        int r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 2)
                item.code = $urandom_range(1) ? OP_NOP_HIGH : OP_NOP_LOW;
            else if (r < push_pct)
                item.code = push_ops[$urandom_range(1)];
            else
                item.code = read_ops[$urandom_range(3)];
            item.arg = pick_value();
            pending_ops.push_back(item);
        end
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || req_ch.valid || want_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(int cap);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= CNT_W'(cap);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_limit = (cap > DEPTH) ? DEPTH : cap;
        front_pos = 0;
        back_pos = 0;
        held = 0;
        n_caps++;
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 21;
                recv_idle_pct = 56;
            end
            1:
            begin
                send_idle_pct = 56;
                recv_idle_pct = 21;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_req
        deque_op_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.opcode <= '0;
            req_ch.push_value <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_ops.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.opcode <= nxt.code;
                req_ch.push_value <= nxt.arg;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_ticket != hold_seen)
        begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : watch_rsp
        rsp_t r;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                r = deque_step(req_ch.opcode, req_ch.push_value);
                want_rsp.push_back(r);
                n_ops++;
                if (!r.ok && (req_ch.opcode == OP_PUSH_FRONT || req_ch.opcode == OP_PUSH_REAR))
                    n_refused++;
                if (!r.ok && req_ch.opcode inside {OP_POP_FRONT, OP_POP_REAR,
                                                   OP_PEEK_FRONT, OP_PEEK_REAR})
                    n_empty_reads++;
                if (r.is_full)
                    n_full_seen++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (want_rsp.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual value %h count %0d",
                             $time, rsp_ch.value, rsp_ch.fill_count);
                    errors++;
                end
                else
                begin
                    r = want_rsp.pop_front();
                    check_field("ok", DATA_W'(r.ok), DATA_W'(rsp_ch.ok));
                    check_field("value", r.value, rsp_ch.value);
                    check_field("is_empty", DATA_W'(r.is_empty), DATA_W'(rsp_ch.is_empty));
                    check_field("is_full", DATA_W'(r.is_full), DATA_W'(rsp_ch.is_full));
                    check_field("fill_count", DATA_W'(r.fill_count), DATA_W'(rsp_ch.fill_count));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wr_en)
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = '0;
        req_ch.push_value = '0;
        rsp_ch.ready = 1'b0;
        cap_limit = DEPTH;
        front_pos = 0;
        back_pos = 0;
        held = 0;
        set_idle(0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        add_op(OP_POP_FRONT, '0);
        add_op(OP_POP_REAR, '0);
        add_op(OP_PEEK_FRONT, '0);
        add_op(OP_PEEK_REAR, '0);
        add_op(OP_NOP_LOW, '1);
        add_op(OP_NOP_HIGH, '0);
        add_op(OP_PUSH_FRONT, 32'h7fff_ffff);
        add_op(OP_PUSH_REAR, 32'h8000_0000);
        add_op(OP_PUSH_FRONT, 32'hffff_ffff);
        add_op(OP_PUSH_REAR, 32'h0000_0000);
        add_op(OP_PEEK_FRONT, '0);
        add_op(OP_PEEK_REAR, '0);
        add_op(OP_NOP_HIGH, 32'h1234_5678);
        add_op(OP_POP_REAR, '0);
        add_op(OP_POP_FRONT, '0);
        add_op(OP_POP_FRONT, '0);
        add_op(OP_POP_REAR, '0);
        add_op(OP_POP_FRONT, '0);

        // A zero capacity leaves the deque empty and full at once.
        set_capacity(0);
        add_op(OP_PUSH_FRONT, 32'h0000_0001);
        add_op(OP_PUSH_REAR, 32'h0000_0002);
        add_op(OP_PEEK_REAR, '0);

        set_idle(0);
        set_capacity(1);
        queue_random(80, 50);
        hold_ticket++;
        set_capacity(2);
        queue_random(100, 50);
        set_capacity(3);
        queue_random(100, 50);

        // The largest setting saturates at the store depth; fill it, then drain part of it.
        set_idle(1);
        set_capacity(2047);
        queue_random(1150, 97);
        queue_random(80, 5);

        set_idle(2);
        set_capacity(5);
        queue_random(100, 50);
        set_capacity(17);
        queue_random(120, 60);
        set_capacity(1024);
        queue_random(80, 50);
        set_capacity(7);
        queue_random(100, 55);

        drain();
        $display("Covered %0d operations over %0d capacity settings after reset.", n_ops, n_caps);
        $display("Saw %0d refused pushes, %0d reads of an empty deque, %0d results at full.",
                 n_refused, n_empty_reads, n_full_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
